// File: sv/sha1md_pkg.sv
// SHA-1 digest core: shared constants, types and round helpers.
// Used by every module of the core; depends on nothing.
package sha1md_pkg;

	localparam int DIGEST_N   = 5;
	localparam int ROUNDS     = 80;
	localparam int BLK_WORDS  = 16;
	localparam int QDEPTH     = 16;
	localparam int QIDX_W     = $clog2(QDEPTH);
	localparam int BYTECNT_W  = 61;

	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [31:0] MARK_WORD = 32'h8000_0000;

	localparam logic [31:0] K0 = 32'h5A82_7999;
	localparam logic [31:0] K1 = 32'h6ED9_EBA1;
	localparam logic [31:0] K2 = 32'h8F1B_BCDC;
	localparam logic [31:0] K3 = 32'hCA62_C1D6;

	localparam logic [31:0] IV [DIGEST_N] = '{
		32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
	};

	// Round group boundaries
	localparam logic [6:0] T_GRP1 = 7'd20;
	localparam logic [6:0] T_GRP2 = 7'd40;
	localparam logic [6:0] T_GRP3 = 7'd60;
	localparam logic [6:0] T_LAST = 7'(ROUNDS - 1);
	localparam logic [6:0] T_LOAD = 7'(BLK_WORDS);

	localparam logic [2:0] LAST_IDX = 3'(DIGEST_N - 1);

	// Word queue entry: one block word, flagged on the last word of a message
	typedef struct packed {
		logic        msg_end;
		logic [31:0] word;
	} word_entry_t;

	// Word queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [1:0] {
		FS_DATA = 2'b01,
		FS_PAD  = 2'b10
	} front_state_t;

	typedef enum logic [1:0] {
		BS_ROUND = 2'b01,
		BS_FOLD  = 2'b10
	} back_state_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

// File: sv/sha1md_front.sv
// SHA-1 digest core front end: packs bytes into words, counts the length
// and generates the padding and length words. Depends on sha1md_pkg.
module sha1md_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	input  sha1md_pkg::queue_stat_t   q_stat,
	output logic                      q_wr,
	output sha1md_pkg::word_entry_t   q_wdata
);

	sha1md_pkg::front_state_t state_q;
	logic [sha1md_pkg::BYTECNT_W-1:0] byte_cnt_q;
	logic [23:0]                      acc_q;
	logic [31:0]                      pad_word_q;
	logic [3:0]                       pidx_q;
	logic                             pad_first_q;
	logic                             mark_q;
	logic                             extra_q;

	logic        accept;
	logic [5:0]  pos;
	logic [1:0]  lane;
	logic [31:0] cur_word;
	logic [23:0] acc_next;
	logic [31:0] pad_out;
	logic        pad_wr;
	logic        pad_blk_end;

	assign accept = push & ~full;
	assign full   = (state_q != sha1md_pkg::FS_DATA) | q_stat.full;
	assign pos    = byte_cnt_q[5:0];
	assign lane   = pos[1:0];

	// Merge the byte into the word; mark the lane after it for padding
	always_comb begin
		unique case (lane)
			2'd0: begin
				cur_word = {data_byte, sha1md_pkg::PAD_MARK, 16'h0000};
				acc_next = {data_byte, 16'h0000};
			end
			2'd1: begin
				cur_word = {acc_q[23:16], data_byte, sha1md_pkg::PAD_MARK, 8'h00};
				acc_next = {acc_q[23:16], data_byte, 8'h00};
			end
			2'd2: begin
				cur_word = {acc_q[23:8], data_byte, sha1md_pkg::PAD_MARK};
				acc_next = {acc_q[23:8], data_byte};
			end
			default: begin
				cur_word = {acc_q, data_byte};
				acc_next = acc_q;
			end
		endcase
	end

	// Select the padding word for the current index
	always_comb begin
		priority if (pad_first_q) begin
			pad_out = pad_word_q;
		end else if (!extra_q && pidx_q == 4'd14) begin
			pad_out = byte_cnt_q[60:29];
		end else if (!extra_q && pidx_q == 4'd15) begin
			pad_out = {byte_cnt_q[28:0], 3'b000};
		end else if (mark_q) begin
			pad_out = sha1md_pkg::MARK_WORD;
		end else begin
			pad_out = '0;
		end
	end

	assign pad_wr      = (state_q == sha1md_pkg::FS_PAD) & ~q_stat.full;
	assign pad_blk_end = (pidx_q == 4'd15);

	// Drive the word queue write port
	always_comb begin
		if (state_q == sha1md_pkg::FS_PAD) begin
			q_wr            = pad_wr;
			q_wdata.word    = pad_out;
			q_wdata.msg_end = pad_blk_end & ~extra_q;
		end else begin
			q_wr            = accept & ~final_byte & (lane == 2'd3);
			q_wdata.word    = cur_word;
			q_wdata.msg_end = 1'b0;
		end
	end

	// Control state: advance on byte transfers and padding writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha1md_pkg::FS_DATA;
			byte_cnt_q  <= '0;
			pidx_q      <= '0;
			pad_first_q <= 1'b0;
			mark_q      <= 1'b0;
			extra_q     <= 1'b0;
		end else begin
			unique case (state_q)
				sha1md_pkg::FS_DATA: begin
					if (accept) begin
						byte_cnt_q <= byte_cnt_q + 1'b1;
						if (final_byte) begin
							state_q     <= sha1md_pkg::FS_PAD;
							pidx_q      <= pos[5:2];
							pad_first_q <= 1'b1;
							mark_q      <= (lane == 2'd3);
							extra_q     <= (pos >= 6'd55);
						end
					end
				end
				sha1md_pkg::FS_PAD: begin
					if (pad_wr) begin
						pad_first_q <= 1'b0;
						if (!pad_first_q) begin
							mark_q <= 1'b0;
						end
						pidx_q <= pidx_q + 1'b1;
						if (pad_blk_end) begin
							if (extra_q) begin
								extra_q <= 1'b0;
							end else begin
								state_q    <= sha1md_pkg::FS_DATA;
								byte_cnt_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= sha1md_pkg::FS_DATA;
				end
			endcase
		end
	end

	// Payload: partial word and first padding word
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_next;
			if (final_byte) begin
				pad_word_q <= cur_word;
			end
		end
	end

	// Never write into a full word queue
	assert property (@(posedge clk) disable iff (!arst_n) q_wr |-> !q_stat.full)
		else $error("front: write into full word queue");

	// Padding always ends on the last word of a block
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1md_pkg::FS_PAD) ##1 (state_q == sha1md_pkg::FS_DATA)
		|-> $past(pidx_q) == 4'd15)
		else $error("front: padding ended off a block boundary");

endmodule

// File: sv/sha1md_queue.sv
// SHA-1 digest core word queue between front and back end.
// Depends on sha1md_pkg.
module sha1md_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr,
	input  sha1md_pkg::word_entry_t wdata,
	input  logic                    rd,
	output sha1md_pkg::word_entry_t rdata,
	output sha1md_pkg::queue_stat_t stat
);

	sha1md_pkg::word_entry_t           mem_q [sha1md_pkg::QDEPTH];
	logic [sha1md_pkg::QIDX_W-1:0]     wptr_q;
	logic [sha1md_pkg::QIDX_W-1:0]     rptr_q;
	logic [sha1md_pkg::QIDX_W:0]       cnt_q;
	logic                              do_wr;
	logic                              do_rd;

	assign stat.full  = (cnt_q == (sha1md_pkg::QIDX_W + 1)'(sha1md_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr & ~stat.full;
	assign do_rd      = rd & ~stat.empty;
	assign rdata      = mem_q[rptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// File: sv/sha1md_back.sv
// SHA-1 digest core back end: 80-round compression, chaining value and
// the five-word digest output buffer. Depends on sha1md_pkg.
module sha1md_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha1md_pkg::queue_stat_t q_stat,
	input  sha1md_pkg::word_entry_t q_rdata,
	output logic                    q_rd,
	output logic                    empty,
	input  logic                    pop,
	output logic [31:0]             digest_word,
	output logic [2:0]              word_index,
	output logic                    final_word
);

	sha1md_pkg::back_state_t state_q;
	logic [6:0]  t_q;
	logic        msg_q;
	logic [31:0] h_q   [sha1md_pkg::DIGEST_N];
	logic [31:0] v_q   [sha1md_pkg::DIGEST_N];
	logic [31:0] w_q   [sha1md_pkg::BLK_WORDS];
	logic [31:0] obuf_q[sha1md_pkg::DIGEST_N];
	logic [2:0]  oidx_q;
	logic        ovld_q;

	logic        loading;
	logic        step;
	logic [31:0] wt;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] h_sum [sha1md_pkg::DIGEST_N];
	logic        fold_go;
	logic        obuf_load;

	assign loading = (t_q < sha1md_pkg::T_LOAD);
	assign step    = (state_q == sha1md_pkg::BS_ROUND) & (~loading | ~q_stat.empty);
	assign q_rd    = (state_q == sha1md_pkg::BS_ROUND) & loading & ~q_stat.empty;

	// Message schedule: queue word for the first sixteen rounds
	assign wt = loading ? q_rdata.word
	                    : sha1md_pkg::rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

	// Round function and constant by round group
	always_comb begin
		priority if (t_q < sha1md_pkg::T_GRP1) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = sha1md_pkg::K0;
		end else if (t_q < sha1md_pkg::T_GRP2) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = sha1md_pkg::K1;
		end else if (t_q < sha1md_pkg::T_GRP3) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k = sha1md_pkg::K2;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = sha1md_pkg::K3;
		end
	end

	assign tmp = sha1md_pkg::rotl5(v_q[0]) + f + v_q[4] + k + wt;

	always_comb begin
		for (int i = 0; i < sha1md_pkg::DIGEST_N; i++) begin
			h_sum[i] = h_q[i] + v_q[i];
		end
	end

	// Fold waits for the output buffer when the block ends a message
	assign fold_go   = (state_q == sha1md_pkg::BS_FOLD) & ~(msg_q & ovld_q);
	assign obuf_load = fold_go & msg_q;

	// Control: round counter, state, output buffer handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1md_pkg::BS_ROUND;
			t_q     <= '0;
			oidx_q  <= '0;
			ovld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				sha1md_pkg::BS_ROUND: begin
					if (step) begin
						if (t_q == sha1md_pkg::T_LAST) begin
							state_q <= sha1md_pkg::BS_FOLD;
						end
						t_q <= t_q + 1'b1;
					end
				end
				sha1md_pkg::BS_FOLD: begin
					if (fold_go) begin
						state_q <= sha1md_pkg::BS_ROUND;
						t_q     <= '0;
					end
				end
				default: begin
					state_q <= sha1md_pkg::BS_ROUND;
				end
			endcase
			if (obuf_load) begin
				ovld_q <= 1'b1;
				oidx_q <= '0;
			end else if (pop && ovld_q) begin
				if (oidx_q == sha1md_pkg::LAST_IDX) begin
					ovld_q <= 1'b0;
					oidx_q <= '0;
				end else begin
					oidx_q <= oidx_q + 1'b1;
				end
			end
		end
	end

	// Chaining value and working variables: reset to the initial value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1md_pkg::DIGEST_N; i++) begin
				h_q[i] <= sha1md_pkg::IV[i];
				v_q[i] <= sha1md_pkg::IV[i];
			end
		end else if (step) begin
			v_q[0] <= tmp;
			v_q[1] <= v_q[0];
			v_q[2] <= sha1md_pkg::rotl30(v_q[1]);
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end else if (fold_go) begin
			for (int i = 0; i < sha1md_pkg::DIGEST_N; i++) begin
				h_q[i] <= msg_q ? sha1md_pkg::IV[i] : h_sum[i];
				v_q[i] <= msg_q ? sha1md_pkg::IV[i] : h_sum[i];
			end
		end
	end

	// Schedule shift line, message flag and digest buffer
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < sha1md_pkg::BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha1md_pkg::BLK_WORDS - 1] <= wt;
		end
		if (q_rd) begin
			msg_q <= q_rdata.msg_end;
		end
		if (obuf_load) begin
			for (int i = 0; i < sha1md_pkg::DIGEST_N; i++) begin
				obuf_q[i] <= h_sum[i];
			end
		end
	end

	assign empty       = ~ovld_q;
	assign digest_word = obuf_q[oidx_q];
	assign word_index  = oidx_q;
	assign final_word  = (oidx_q == sha1md_pkg::LAST_IDX);

	// Round counter stays inside one block
	assert property (@(posedge clk) disable iff (!arst_n)
		t_q <= 7'(sha1md_pkg::ROUNDS))
		else $error("back: round counter out of range");

	// Digest buffer is loaded only after the previous digest is drained
	assert property (@(posedge clk) disable iff (!arst_n) obuf_load |-> !ovld_q)
		else $error("back: digest buffer overwritten");

endmodule

// File: sv/sha1_message_digest_core.sv
// SHA-1 message digest core, top level.
// Instantiates sha1md_front, sha1md_queue and sha1md_back; uses sha1md_pkg.
//
// Bytes of a message are pushed one per cycle while full is low, the last one
// flagged with final_byte; after it the five digest words come out in order
// (H0 first, final_word set on the fifth) and the core starts over on a fresh
// message. The front end takes a byte every cycle while its sixteen-word
// queue has room, and after the last byte writes the padding and length
// words, during which full is high. The back end runs one SHA-1 round per
// cycle while it is not waiting on an empty queue for its sixteen block words:
// a 64-byte block takes 80 rounds plus one fold into the chaining value, and
// the round loop sets the rate of a long message. Digest words wait in a
// five-word output buffer; the back end holds the next message's final fold
// until that buffer has been drained.
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);

	sha1md_pkg::queue_stat_t q_stat;
	sha1md_pkg::word_entry_t q_wdata;
	sha1md_pkg::word_entry_t q_rdata;
	logic                    q_wr;
	logic                    q_rd;

	sha1md_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_stat     (q_stat),
		.q_wr       (q_wr),
		.q_wdata    (q_wdata)
	);

	sha1md_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	sha1md_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_rdata     (q_rdata),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.final_word  (final_word)
	);

endmodule
